// ===== rtl/core/sfsd_pkg.sv =====
// Shared types, constants and lookup functions for the sound frame stream decoder.
package sfsd_pkg;

    localparam int CHANNELS   = 8;
    localparam int COUNT_BITS = 16;
    localparam int CH_BITS    = 3;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] CLS_VOLUME  = 4'h8;
    localparam logic [3:0] CLS_DUTY    = 4'h9;
    localparam logic [3:0] CLS_TRIGGER = 4'h7;

    localparam logic [1:0] WAVE_NOISE  = 2'd2;
    localparam logic [1:0] WAVE_SAMPLE = 2'd3;

    typedef struct packed {
        logic        enable;
        logic [3:0]  volume;
        logic [1:0]  duty;
        logic [1:0]  wave;
        logic [10:0] period;
    } t_voice;

    typedef struct packed {
        logic [1:0]            kind;
        logic [CH_BITS-1:0]    channel;
        t_voice                voice;
        logic [COUNT_BITS-1:0] byte_count;
        logic                  last;
    } t_result;

    function automatic logic [1:0] dflt_wave(input logic [CH_BITS-1:0] ch);
        logic [1:0] w;
        case (ch)
            3'd2:    w = 2'd1;
            3'd3:    w = 2'd2;
            3'd4:    w = 2'd3;
            3'd7:    w = 2'd2;
            default: w = 2'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] letter_semi(input logic [3:0] l);
        logic [3:0] s;
        case (l)
            4'h0:    s = 4'd7;
            4'hA:    s = 4'd9;
            4'hB:    s = 4'd11;
            4'hD:    s = 4'd2;
            4'hE:    s = 4'd4;
            4'hF:    s = 4'd5;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // period for midi index 12..96 (offset 0..84)
    function automatic logic [10:0] midi_period(input logic [6:0] i);
        logic [10:0] p;
        case (i)
            7'd4: p = 11'd1070; 7'd5: p = 11'd1010; 7'd6: p = 11'd954;
            7'd7: p = 11'd900;  7'd8: p = 11'd850;  7'd9: p = 11'd802;
            7'd10: p = 11'd757; 7'd11: p = 11'd714; 7'd12: p = 11'd674;
            7'd13: p = 11'd636; 7'd14: p = 11'd601; 7'd15: p = 11'd567;
            7'd16: p = 11'd535; 7'd17: p = 11'd505; 7'd18: p = 11'd477;
            7'd19: p = 11'd450; 7'd20: p = 11'd425; 7'd21: p = 11'd401;
            7'd22: p = 11'd378; 7'd23: p = 11'd357; 7'd24: p = 11'd337;
            7'd25: p = 11'd318; 7'd26: p = 11'd300; 7'd27: p = 11'd283;
            7'd28: p = 11'd268; 7'd29: p = 11'd253; 7'd30: p = 11'd238;
            7'd31: p = 11'd225; 7'd32: p = 11'd212; 7'd33: p = 11'd200;
            7'd34: p = 11'd189; 7'd35: p = 11'd179; 7'd36: p = 11'd169;
            7'd37: p = 11'd159; 7'd38: p = 11'd150; 7'd39: p = 11'd142;
            7'd40: p = 11'd134; 7'd41: p = 11'd126; 7'd42: p = 11'd119;
            7'd43: p = 11'd113; 7'd44: p = 11'd106; 7'd45: p = 11'd100;
            7'd46: p = 11'd95;  7'd47: p = 11'd89;  7'd48: p = 11'd84;
            7'd49: p = 11'd80;  7'd50: p = 11'd75;  7'd51: p = 11'd71;
            7'd52: p = 11'd67;  7'd53: p = 11'd63;  7'd54: p = 11'd60;
            7'd55: p = 11'd56;  7'd56: p = 11'd53;  7'd57: p = 11'd50;
            7'd58: p = 11'd47;  7'd59: p = 11'd45;  7'd60: p = 11'd42;
            7'd61: p = 11'd40;  7'd62: p = 11'd38;  7'd63: p = 11'd35;
            7'd64: p = 11'd33;  7'd65: p = 11'd32;  7'd66: p = 11'd30;
            7'd67: p = 11'd28;  7'd68: p = 11'd27;  7'd69: p = 11'd25;
            7'd70: p = 11'd24;  7'd71: p = 11'd22;  7'd72: p = 11'd21;
            7'd73: p = 11'd20;  7'd74: p = 11'd19;  7'd75: p = 11'd18;
            7'd76: p = 11'd17;  7'd77: p = 11'd16;  7'd78: p = 11'd15;
            7'd79: p = 11'd14;  7'd80: p = 11'd13;  7'd81: p = 11'd13;
            7'd82: p = 11'd12;  7'd83: p = 11'd11;  7'd84: p = 11'd11;
            default: p = 11'd0;
        endcase
        return p;
    endfunction

    function automatic logic [10:0] note_period(input logic [7:0] note);
        logic [3:0] l;
        logic [6:0] midi;
        l = note[7:4];
        midi = 7'(({4'd0, note[2:0]} + 7'd1) * 7'd12) + {3'd0, letter_semi(l)}
               - {6'd0, note[3]};
        if (l > 4'd0 && l < 4'hA) begin
            return 11'd32;
        end
        if (midi < 7'd12) midi = 7'd12;
        if (midi > 7'd96) midi = 7'd96;
        return midi_period(7'(midi - 7'd12));
    endfunction

endpackage

// ===== rtl/core/sfsd_voice_unit.sv =====
// Shared voice update unit: applies one payload byte to one voice.
module sfsd_voice_unit (
    input  logic [sfsd_pkg::CH_BITS-1:0] i_ch,
    input  logic [7:0]                   i_byte,
    input  sfsd_pkg::t_voice             i_voice,
    output sfsd_pkg::t_voice             o_voice
);
    logic [3:0]  hi, lo;
    logic        en;
    logic [3:0]  vol;
    logic [1:0]  duty, wave;
    logic [10:0] per;

    always_comb begin
        hi = i_byte[7:4];
        lo = i_byte[3:0];
        en = i_voice.enable;  vol = i_voice.volume;  duty = i_voice.duty;
        wave = i_voice.wave;  per = i_voice.period;
        if (wave == 2'd0 && !en && per == 11'd0) wave = sfsd_pkg::dflt_wave(i_ch);
        if (hi == sfsd_pkg::CLS_VOLUME) begin
            vol = lo;
            en  = (lo != 4'd0);
            if (!en) per = 11'd0;
        end else if (hi == sfsd_pkg::CLS_DUTY) begin
            duty = lo[1:0];
            if (i_ch == 3'd3) begin
                wave = sfsd_pkg::WAVE_NOISE;
                per  = 11'd8 + {5'd0, lo, 2'b00};
                en   = 1'b1;
                if (vol == 4'd0) vol = 4'd10;
            end
        end else if (hi == sfsd_pkg::CLS_TRIGGER) begin
            if (i_ch == 3'd4) begin
                wave = sfsd_pkg::WAVE_SAMPLE;
                en   = 1'b1;
                vol  = 4'd12;
                per  = (lo != 4'd0) ? 11'd40 : 11'd24;
            end
        end else begin
            per  = sfsd_pkg::note_period(i_byte);
            en   = (per >= 11'd2);
            if (vol == 4'd0) vol = (i_ch == 3'd2) ? 4'd15 : 4'd12;
            wave = sfsd_pkg::dflt_wave(i_ch);
            if (i_ch == 3'd0)      duty = 2'd2;
            else if (i_ch == 3'd1) duty = 2'd1;
        end
        o_voice = '{enable: en, volume: vol, duty: duty, wave: wave, period: per};
    end
endmodule

// ===== rtl/core/sound_frame_stream_decoder_core.sv =====
// Top level of the sound frame stream decoder: parser, commit sequencer, output register.
// Takes one stream byte per item. Opcode, mask and payload bytes are each accepted while
// the output register is free or being taken. The last payload byte of a frame starts a
// commit walk, one channel per step over all eight through the single shared voice update
// unit; each voice whose mask bit is set is sent out as an update item, then the ok status
// if the byte ended the stream. A walk step waits while a result is held in the output register.
// s_axis_tready is low during the walk and while a result waits in the output register.
module sound_frame_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // frame_opcode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // stream_byte
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] channel, [3] enable, [7:4] volume, [9:8] duty, [11:10] wave,
    // [22:12] period, [38:23] byte_count, [39] zero fill
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);
    localparam int CB = sfsd_pkg::COUNT_BITS;

    typedef enum logic [2:0] {S_OPCODE, S_MASK, S_PAYLOAD, S_DROP, S_COMMIT, S_STATUS}
        t_state;

    t_state                 r_state, n_state;
    logic [7:0]             r_opcode;
    logic [7:0]             r_mask, n_mask;
    logic [7:0]             r_buf [8];
    logic [3:0]             r_seen, n_seen;
    logic [CB-1:0]          r_count, n_count;
    sfsd_pkg::t_voice       r_bank [sfsd_pkg::CHANNELS];
    logic [2:0]             r_ch, n_ch;
    logic [2:0]             r_k, n_k;
    logic                   r_eos, n_eos;
    logic                   r_ovalid, n_ovalid;
    sfsd_pkg::t_result      r_out, n_out;

    logic                   in_acc, out_free, bank_we;
    logic [3:0]             pop;
    sfsd_pkg::t_voice       vu_in, vu_out;
    logic [CB-1:0]          cnt_inc;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = out_free &&
        (r_state == S_OPCODE || r_state == S_MASK || r_state == S_PAYLOAD || r_state == S_DROP);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {1'b0, r_out.byte_count, r_out.voice.period, r_out.voice.wave,
                            r_out.voice.duty, r_out.voice.volume, r_out.voice.enable,
                            r_out.channel};

    assign pop     = 4'($countones(r_mask));
    assign cnt_inc = (&r_count) ? r_count : r_count + CB'(1);
    assign vu_in   = r_bank[r_ch];

    sfsd_voice_unit u_vu (.i_ch(r_ch), .i_byte(r_buf[r_k]), .i_voice(vu_in), .o_voice(vu_out));

    always_comb begin
        n_state = r_state;  n_mask = r_mask;  n_seen = r_seen;  n_count = r_count;
        n_ch = r_ch;  n_k = r_k;  n_eos = r_eos;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_out = r_out;
        bank_we = 1'b0;
        unique case (r_state)
            S_OPCODE: if (in_acc) begin
                if (s_axis_tdata != r_opcode || s_axis_tlast) begin
                    n_ovalid = 1'b1;
                    n_out = '{kind: sfsd_pkg::KIND_ERROR, last: 1'b1, default: '0};
                    n_state = s_axis_tlast ? S_OPCODE : S_DROP;
                    if (s_axis_tlast) n_count = '0;
                end else begin
                    n_count = cnt_inc;
                    n_state = S_MASK;
                end
            end
            S_MASK: if (in_acc) begin
                n_count = cnt_inc;
                n_mask = s_axis_tdata;
                n_seen = '0;
                if (s_axis_tdata == 8'd0) begin
                    n_state = S_OPCODE;
                    if (s_axis_tlast) begin
                        n_ovalid = 1'b1;
                        n_out = '{kind: sfsd_pkg::KIND_OK, last: 1'b1, byte_count: cnt_inc,
                                  default: '0};
                        n_count = '0;
                    end
                end else if (s_axis_tlast) begin
                    n_ovalid = 1'b1;
                    n_out = '{kind: sfsd_pkg::KIND_ERROR, last: 1'b1, default: '0};
                    n_count = '0;
                    n_state = S_OPCODE;
                end else begin
                    n_state = S_PAYLOAD;
                end
            end
            S_PAYLOAD: if (in_acc) begin
                n_count = cnt_inc;
                n_seen = r_seen + 4'd1;
                if (r_seen + 4'd1 >= pop) begin
                    n_state = S_COMMIT;
                    n_ch = '0;  n_k = '0;  n_eos = s_axis_tlast;
                end else if (s_axis_tlast) begin
                    n_ovalid = 1'b1;
                    n_out = '{kind: sfsd_pkg::KIND_ERROR, last: 1'b1, default: '0};
                    n_count = '0;
                    n_state = S_OPCODE;
                end
            end
            S_DROP: if (in_acc && s_axis_tlast) begin
                n_state = S_OPCODE;
                n_count = '0;
            end
            S_COMMIT: if (out_free) begin
                if (r_mask[r_ch]) begin
                    bank_we = 1'b1;
                    n_ovalid = 1'b1;
                    n_out = '{kind: sfsd_pkg::KIND_UPDATE, channel: r_ch, voice: vu_out,
                              byte_count: '0,
                              last: !r_eos && ((r_mask >> r_ch) == 8'd1)};
                    n_k = r_k + 3'd1;
                end
                n_ch = r_ch + 3'd1;
                if (r_ch == 3'd7) n_state = r_eos ? S_STATUS : S_OPCODE;
            end
            S_STATUS: if (out_free) begin
                n_ovalid = 1'b1;
                n_out = '{kind: sfsd_pkg::KIND_OK, last: 1'b1, byte_count: r_count,
                          default: '0};
                n_count = '0;
                n_state = S_OPCODE;
            end
            default: n_state = S_OPCODE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_OPCODE;  r_opcode <= '0;  r_mask <= '0;  r_seen <= '0;
            r_count <= '0;  r_ch <= '0;  r_k <= '0;  r_eos <= 1'b0;  r_ovalid <= 1'b0;
            for (int i = 0; i < sfsd_pkg::CHANNELS; i++) r_bank[i] <= '0;
        end else begin
            r_state <= n_state;  r_mask <= n_mask;  r_seen <= n_seen;  r_count <= n_count;
            r_ch <= n_ch;  r_k <= n_k;  r_eos <= n_eos;  r_ovalid <= n_ovalid;
            if (i_cfg_valid) r_opcode <= i_cfg_data;
            if (bank_we) r_bank[r_ch] <= vu_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_PAYLOAD && in_acc) r_buf[r_seen[2:0]] <= s_axis_tdata;
    end
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sound frame stream decoder core.
`timescale 1ns / 1ps

module tb_top;

    // Expected result as seen on the master side.
    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  channel;
        logic        enable;
        logic [3:0]  volume;
        logic [1:0]  duty;
        logic [1:0]  wave;
        logic [10:0] period;
        logic [15:0] byte_count;
        logic        last;
    } t_exp;

    typedef enum logic [1:0] {
        ST_OPCODE  = 2'd0,
        ST_MASK    = 2'd1,
        ST_PAYLOAD = 2'd2,
        ST_DROP    = 2'd3
    } t_phase;

    // Periods for midi 12..96 (offset 0..84).
    localparam logic [10:0] MIDI_PER [0:84] = '{
        0, 0, 0, 0, 1070, 1010, 954, 900, 850, 802, 757, 714,
        674, 636, 601, 567, 535, 505, 477, 450, 425, 401, 378, 357,
        337, 318, 300, 283, 268, 253, 238, 225, 212, 200, 189, 179,
        169, 159, 150, 142, 134, 126, 119, 113, 106, 100, 95, 89,
        84, 80, 75, 71, 67, 63, 60, 56, 53, 50, 47, 45,
        42, 40, 38, 35, 33, 32, 30, 28, 27, 25, 24, 22,
        21, 20, 19, 18, 17, 16, 15, 14, 13, 13, 12, 11, 11};
    localparam logic [1:0] HOME_WAVE [0:7] = '{0, 0, 1, 2, 3, 0, 0, 2};
    localparam int         LETTER_SEMI [0:15] = '{7, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                                  9, 11, 0, 2, 4, 5};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sound_frame_stream_decoder_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder shadow state.
    logic [7:0]        opcode_reg;
    t_phase            phase;
    logic [7:0]        cur_mask;
    logic [7:0]        pay_buf [0:7];
    int                pay_seen;
    int                byte_cnt;
    sfsd_pkg::t_voice  bank [0:7];

    t_exp        pending_q[$];
    int          n_fail, n_items, n_results, n_ok, n_err;
    bit          rx_stall_free;
    int          rx_seen = 0;
    int          rx_gap = 0;

    function automatic logic [10:0] period_of_note(logic [7:0] note);
        int l, midi;
        l = note[7:4];
        if (l > 0 && l < 10) return 11'd32;
        midi = (note[2:0] + 1) * 12 + LETTER_SEMI[l] - note[3];
        if (midi < 12) midi = 12;
        if (midi > 96) midi = 96;
        return MIDI_PER[midi - 12];
    endfunction

    function automatic sfsd_pkg::t_voice voice_after(int ch, sfsd_pkg::t_voice v,
                                                     logic [7:0] b);
        sfsd_pkg::t_voice r;
        r = v;
        if (r.wave == 0 && !r.enable && r.period == 0) r.wave = HOME_WAVE[ch];
        case (b[7:4])
            sfsd_pkg::CLS_VOLUME: begin
                r.volume = b[3:0];
                r.enable = b[3:0] != 0;
                if (!r.enable) r.period = 0;
            end
            sfsd_pkg::CLS_DUTY: begin
                r.duty = b[1:0];
                if (ch == 3) begin
                    r.wave = sfsd_pkg::WAVE_NOISE;
                    r.period = 11'(8 + b[3:0] * 4);
                    r.enable = 1'b1;
                    if (r.volume == 0) r.volume = 4'd10;
                end
            end
            sfsd_pkg::CLS_TRIGGER: begin
                if (ch == 4) begin
                    r.wave = sfsd_pkg::WAVE_SAMPLE;
                    r.enable = 1'b1;
                    r.volume = 4'd12;
                    r.period = (b[3:0] != 0) ? 11'd40 : 11'd24;
                end
            end
            default: begin
                r.period = period_of_note(b);
                r.enable = r.period >= 2;
                if (r.volume == 0) r.volume = (ch == 2) ? 4'd15 : 4'd12;
                r.wave = HOME_WAVE[ch];
                if (ch == 0) r.duty = 2'd2;
                else if (ch == 1) r.duty = 2'd1;
            end
        endcase
        return r;
    endfunction

    task automatic push_status(logic [1:0] kind, int cnt);
        t_exp e;
        e = '{kind, 3'd0, 1'b0, 4'd0, 2'd0, 2'd0, 11'd0, 16'(cnt), 1'b0};
        pending_q.push_back(e);
    endtask

    // Advance the shadow decoder by one byte and queue what it emits.
    task automatic predict_byte(logic [7:0] b, logic eos);
        bit done, bad;
        int first, k;
        t_exp e;
        done = 0;
        bad = 0;
        first = pending_q.size();
        case (phase)
            ST_OPCODE: begin
                if (b != opcode_reg || eos) bad = 1;
                else begin
                    if (byte_cnt < 65535) byte_cnt++;
                    phase = ST_MASK;
                end
            end
            ST_MASK: begin
                if (byte_cnt < 65535) byte_cnt++;
                cur_mask = b;
                pay_seen = 0;
                if (b == 0) done = 1;
                else if (eos) bad = 1;
                else phase = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (byte_cnt < 65535) byte_cnt++;
                pay_buf[pay_seen] = b;
                pay_seen++;
                if (pay_seen >= $countones(cur_mask)) begin
                    k = 0;
                    for (int ch = 0; ch < 8; ch++) begin
                        if (cur_mask[ch]) begin
                            bank[ch] = voice_after(ch, bank[ch], pay_buf[k]);
                            e = '{sfsd_pkg::KIND_UPDATE, 3'(ch), bank[ch].enable,
                                  bank[ch].volume, bank[ch].duty, bank[ch].wave,
                                  bank[ch].period, 16'd0, 1'b0};
                            pending_q.push_back(e);
                            k++;
                        end
                    end
                    done = 1;
                end else if (eos) bad = 1;
            end
            default: begin
                // dropping rest of a failed stream
                if (eos) begin
                    phase = ST_OPCODE;
                    byte_cnt = 0;
                end
                return;
            end
        endcase
        if (done) begin
            phase = ST_OPCODE;
            if (eos) begin
                push_status(sfsd_pkg::KIND_OK, byte_cnt);
                byte_cnt = 0;
            end
        end else if (bad) begin
            push_status(sfsd_pkg::KIND_ERROR, 0);
            if (eos) begin
                phase = ST_OPCODE;
                byte_cnt = 0;
            end else phase = ST_DROP;
        end
        if (pending_q.size() > first) pending_q[$].last = 1'b1;
    endtask

    // Send one stream item after a random gap; tvalid is dropped only for a gap
    // or by drain, so back to back items keep it high.
    task automatic send_byte(logic [7:0] b, logic eos);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(b, eos);
        n_items++;
        @(negedge i_clk);
    endtask

    // Wait for all results, then keep idling so that a commit walk still in progress can finish.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_opcode(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        opcode_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One frame: opcode, mask, one payload per set bit.
    task automatic send_frame(logic [7:0] mask, logic eos, bit rand_pay = 1,
                              logic [7:0] pay = 8'h00);
        int np;
        np = $countones(mask);
        send_byte(opcode_reg, 1'b0);
        send_byte(mask, eos && np == 0);
        for (int i = 0; i < np; i++)
            send_byte(rand_pay ? 8'($urandom) : pay, eos && i == np - 1);
    endtask

    function automatic logic [7:0] rand_payload();
        case ($urandom_range(0, 4))
            0: return {sfsd_pkg::CLS_VOLUME, 4'($urandom)};
            1: return {sfsd_pkg::CLS_DUTY, 4'($urandom)};
            2: return {sfsd_pkg::CLS_TRIGGER, 4'($urandom)};
            default: return 8'($urandom);
        endcase
    endfunction

    // Output back-pressure: after each taken result, tready is held low for a random gap unless rx_stall_free is set.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_seen != n_results) begin
                rx_seen = n_results;
                rx_gap = rx_stall_free ? 0 : $urandom_range(0, 7);
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_exp e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result tdata=%h", m_axis_tdata);
            end else begin
                e = pending_q.pop_front();
                if (m_axis_tuser != e.kind || m_axis_tdata[2:0] != e.channel ||
                    m_axis_tdata[3] != e.enable || m_axis_tdata[7:4] != e.volume ||
                    m_axis_tdata[9:8] != e.duty || m_axis_tdata[11:10] != e.wave ||
                    m_axis_tdata[22:12] != e.period ||
                    m_axis_tdata[38:23] != e.byte_count || m_axis_tdata[39] != 1'b0 ||
                    m_axis_tlast != e.last) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: exp kind=%0d ch=%0d en=%0d vol=%0d duty=%0d wave=%0d per=%0d cnt=%0d last=%0d | got kind=%0d tdata=%h last=%0d",
                                 e.kind, e.channel, e.enable, e.volume, e.duty, e.wave,
                                 e.period, e.byte_count, e.last, m_axis_tuser,
                                 m_axis_tdata, m_axis_tlast);
                end
                if (e.kind == sfsd_pkg::KIND_OK) n_ok++;
                if (e.kind == sfsd_pkg::KIND_ERROR) n_err++;
            end
        end
    end

    // Volume, duty, trigger on every channel; notes on ch 0 to 3: highest, low, a reserved letter.
    task automatic test_directed_frames;
        send_frame(8'h00, 1'b0);                          // empty frame
        send_frame(8'hFF, 1'b0, 0, 8'h8F);                // volume max everywhere
        send_frame(8'hFF, 1'b0, 0, 8'h93);                // duty / noise rate
        send_frame(8'hFF, 1'b0, 0, 8'h70);                // trigger, short sample
        send_byte(opcode_reg, 0); send_byte(8'h18, 0);
        send_byte(8'h80, 0); send_byte(8'h7F, 0);         // mute ch3, long sample ch4
        send_byte(opcode_reg, 0); send_byte(8'h0F, 0);
        send_byte(8'h00, 0); send_byte(8'hFF, 0);         // a low note and the highest note
        send_byte(8'h35, 0); send_byte(8'hB7, 1);         // reserved letter, high B
        drain();
    endtask

    task automatic test_stream_errors;
        send_byte(opcode_reg ^ 8'h5A, 0);                 // bad opcode
        send_byte(8'hFF, 0); send_byte(8'h00, 1);         // dropped to end
        send_byte(opcode_reg, 1);                         // opcode as last byte
        send_byte(opcode_reg, 0); send_byte(8'h03, 1);    // ends after mask
        send_byte(opcode_reg, 0); send_byte(8'h03, 0);
        send_byte(8'hA4, 1);                              // ends mid payload
        send_frame(8'h00, 1'b1);                          // ok with empty frame
        drain();
    endtask

    task automatic test_random_streams(int n_bytes);
        int start, nfr, m, k;
        start = n_items;
        while (n_items - start < n_bytes) begin
            nfr = $urandom_range(1, 5);
            for (int f = 0; f < nfr; f++) begin
                m = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 255);
                if ($urandom_range(0, 9) == 0) begin
                    // broken unless the opcode matches and the mask is 0: bad opcode or early end
                    if ($urandom_range(0, 1)) send_byte(8'($urandom), 0);
                    else send_byte(opcode_reg, 0);
                    send_byte(8'(m), 1);
                    break;
                end
                send_byte(opcode_reg, 0);
                send_byte(8'(m), f == nfr - 1 && m == 0);
                k = 0;
                for (int c = 0; c < 8; c++)
                    if (m[c]) begin
                        k++;
                        send_byte(rand_payload(), f == nfr - 1 && k == $countones(m));
                    end
            end
        end
        drain();
    endtask

    initial begin
        opcode_reg = 8'h00;
        phase = ST_OPCODE;
        cur_mask = '0;
        pay_seen = 0;
        byte_cnt = 0;
        foreach (bank[i]) bank[i] = '0;
        n_fail = 0; n_items = 0; n_results = 0; n_ok = 0; n_err = 0;
        rx_stall_free = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_frames();                 // reset opcode 0
        write_opcode(8'hFF);
        test_stream_errors();
        write_opcode(8'hA5);
        rx_stall_free = 1;
        test_random_streams(120);
        rx_stall_free = 0;
        write_opcode(8'h5A);
        test_random_streams(250);
        write_opcode(8'h00);
        test_random_streams(130);

        $display("covered %0d stream items, %0d results (%0d ok, %0d error status)",
                 n_items, n_results, n_ok, n_err);
        $display("four opcode settings incl. 0x00 and 0xFF, random gaps and stalls");
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
